>>> design/hvs_pkg.sv
// ----------------------------------------------------------------------------
// hvs_pkg
// Shared types and constants of the vertical Haar split block.
// ----------------------------------------------------------------------------
package hvs_pkg;

  localparam int PosBits         = 11;   // row and column positions
  localparam int CfgBits         = 12;   // frame size registers
  localparam int ApbAddrBits     = 3;
  localparam int ApbDataBits     = 32;
  localparam int DefMaxWidth     = 2048;
  localparam int DefMaxHeight    = 2048;
  localparam int DefSampleBits   = 16;
  localparam logic [CfgBits-1:0] WidthReset  = 12'd2048;
  localparam logic [CfgBits-1:0] HeightReset = 12'd2048;

  // register index, taken from the word address
  typedef enum logic [0:0] {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } reg_idx_e;

  // effective frame geometry, already clamped
  typedef struct packed {
    logic [CfgBits-1:0] width_m1;
    logic [CfgBits-1:0] height_m1;
    logic [CfgBits-1:0] half_rows;   // ceil(height/2)
  } cfg_t;

  // position info that travels with a sample
  typedef struct packed {
    logic [PosBits-1:0] out_row;
    logic [PosBits-1:0] out_col;
    logic               is_highpass;
    logic               frame_done;
  } pos_t;

endpackage

>>> design/hvs_cfg.sv
// ----------------------------------------------------------------------------
// hvs_cfg
// APB register file for frame width and height, with range clamping.
// ----------------------------------------------------------------------------
module hvs_cfg #(
  parameter int MaxWidth  = hvs_pkg::DefMaxWidth,
  parameter int MaxHeight = hvs_pkg::DefMaxHeight
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hvs_pkg::ApbAddrBits-1:0]  paddr,
  input  logic [hvs_pkg::ApbDataBits-1:0]  pwdata,
  output logic [hvs_pkg::ApbDataBits-1:0]  prdata,
  output logic                             pready,
  output hvs_pkg::cfg_t                    cfg_o
);

  logic [hvs_pkg::CfgBits-1:0] width_q, width_d;
  logic [hvs_pkg::CfgBits-1:0] height_q, height_d;
  logic [hvs_pkg::CfgBits-1:0] eff_width, eff_height;
  logic [hvs_pkg::CfgBits:0]   height_p1;
  hvs_pkg::reg_idx_e           reg_idx;
  logic                        wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = hvs_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    prdata   = '0;
    case (reg_idx)
      hvs_pkg::RegFrameWidth: begin
        prdata = hvs_pkg::ApbDataBits'(width_q);
        if (wr_en) width_d = pwdata[hvs_pkg::CfgBits-1:0];
      end
      hvs_pkg::RegFrameHeight: begin
        prdata = hvs_pkg::ApbDataBits'(height_q);
        if (wr_en) height_d = pwdata[hvs_pkg::CfgBits-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= hvs_pkg::WidthReset;
      height_q <= hvs_pkg::HeightReset;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // clamp width to 1..MaxWidth and height to 2..MaxHeight
  always_comb begin
    if (width_q == '0) begin
      eff_width = hvs_pkg::CfgBits'(1);
    end else if (int'(width_q) > MaxWidth) begin
      eff_width = hvs_pkg::CfgBits'(MaxWidth);
    end else begin
      eff_width = width_q;
    end
    if (height_q < hvs_pkg::CfgBits'(2)) begin
      eff_height = hvs_pkg::CfgBits'(2);
    end else if (int'(height_q) > MaxHeight) begin
      eff_height = hvs_pkg::CfgBits'(MaxHeight);
    end else begin
      eff_height = height_q;
    end
  end

  assign height_p1       = {1'b0, eff_height} + (hvs_pkg::CfgBits+1)'(1);
  assign cfg_o.width_m1  = eff_width - hvs_pkg::CfgBits'(1);
  assign cfg_o.height_m1 = eff_height - hvs_pkg::CfgBits'(1);
  assign cfg_o.half_rows = height_p1[hvs_pkg::CfgBits:1];

endmodule

>>> design/hvs_front.sv
// ----------------------------------------------------------------------------
// hvs_front
// Row/column tracking, line memory and the input register stage.
// ----------------------------------------------------------------------------
module hvs_front #(
  parameter int MaxWidth   = hvs_pkg::DefMaxWidth,
  parameter int SampleBits = hvs_pkg::DefSampleBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hvs_pkg::cfg_t         cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SampleBits-1:0] sample_i,
  input  logic                  out_free_i,
  output logic                  s1_valid_o,
  output logic [SampleBits-1:0] s1_sample_o,
  output logic [SampleBits-1:0] s1_even_o,
  output hvs_pkg::pos_t         s1_pos_o
);

  localparam int PosBits   = hvs_pkg::PosBits;
  localparam int LineDepth = (MaxWidth > (1 << PosBits)) ? (1 << PosBits) : MaxWidth;
  localparam int AddrBits  = (LineDepth > 1) ? $clog2(LineDepth) : 1;

  logic [SampleBits-1:0]      line_mem [LineDepth];
  logic [SampleBits-1:0]      even_q;
  logic [SampleBits-1:0]      sample_q;
  hvs_pkg::pos_t              pos_q, pos_d;
  logic                       s1_valid_q, s1_valid_d;
  logic [PosBits-1:0]         row_q, row_d;
  logic [PosBits-1:0]         col_q, col_d;
  logic [AddrBits-1:0]        slot;
  logic [hvs_pkg::CfgBits-1:0] row_sum;
  logic                       accept;
  logic                       row_end;
  logic                       done;

  assign in_stall_o = s1_valid_q && !out_free_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign slot       = col_q[AddrBits-1:0];

  assign row_end = {1'b0, col_q} >= cfg_i.width_m1;
  assign done    = row_end && ({1'b0, row_q} >= cfg_i.height_m1);
  assign row_sum = hvs_pkg::CfgBits'(row_q >> 1) + cfg_i.half_rows;

  always_comb begin
    pos_d.out_col     = col_q;
    pos_d.is_highpass = row_q[0];
    pos_d.frame_done  = done;
    pos_d.out_row     = row_q[0] ? row_sum[PosBits-1:0] : (row_q >> 1);

    row_d = row_q;
    col_d = col_q;
    if (accept) begin
      if (done) begin
        row_d = '0;
        col_d = '0;
      end else if (row_end) begin
        row_d = row_q + PosBits'(1);
        col_d = '0;
      end else begin
        col_d = col_q + PosBits'(1);
      end
    end

    s1_valid_d = accept || (s1_valid_q && !out_free_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // even rows fill the line, odd rows read back the matching column
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (!row_q[0]) begin
        line_mem[slot] <= sample_i;
      end else begin
        even_q <= line_mem[slot];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
      pos_q    <= pos_d;
    end
  end

  assign s1_valid_o  = s1_valid_q;
  assign s1_sample_o = sample_q;
  assign s1_even_o   = even_q;
  assign s1_pos_o    = pos_q;

endmodule

>>> design/hvs_back.sv
// ----------------------------------------------------------------------------
// hvs_back
// Low/high-pass selection and the output register.
// ----------------------------------------------------------------------------
module hvs_back #(
  parameter int SampleBits = hvs_pkg::DefSampleBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s1_valid_i,
  input  logic [SampleBits-1:0]       s1_sample_i,
  input  logic [SampleBits-1:0]       s1_even_i,
  input  hvs_pkg::pos_t               s1_pos_i,
  output logic                        out_free_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [SampleBits-1:0]       coefficient_o,
  output logic [hvs_pkg::PosBits-1:0] out_row_o,
  output logic [hvs_pkg::PosBits-1:0] out_col_o,
  output logic                        is_highpass_o,
  output logic                        frame_done_o
);

  logic [SampleBits-1:0] coef_d, coef_q;
  hvs_pkg::pos_t         pos_q;
  logic                  out_valid_q, out_valid_d;
  logic                  load;

  assign out_free_o = !out_valid_q || !out_stall_i;
  assign load       = s1_valid_i && out_free_o;

  // high-pass wraps to the sample width
  assign coef_d = s1_pos_i.is_highpass ? (s1_even_i - s1_sample_i) : s1_sample_i;

  always_comb begin
    out_valid_d = load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      coef_q <= coef_d;
      pos_q  <= s1_pos_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign coefficient_o = coef_q;
  assign out_row_o     = pos_q.out_row;
  assign out_col_o     = pos_q.out_col;
  assign is_highpass_o = pos_q.is_highpass;
  assign frame_done_o  = pos_q.frame_done;

endmodule

>>> design/haar_vertical_split.sv
// The block takes one sample per clock in row-major order while in_stall_o
// is low and returns one coefficient per sample, at one per clock while
// out_stall_i is low: an even row's sample goes out unchanged as low-pass and
// is kept in a line memory of MAX_WIDTH words (at most 2048), an odd row's
// sample goes out as the wrapped difference buffered minus current, placed in
// the lower half of the split plane. An accepted sample's result passes
// through the registered read of the line memory (one write or one read per
// cycle) and the output register. in_stall_o rises only when both of these
// registers hold a transaction and the output is stalled. Row and column
// counters restart after the frame's last sample, which is flagged by frame_done_o.
// ----------------------------------------------------------------------------
// haar_vertical_split
// Streaming vertical forward Haar split, top level.
// ----------------------------------------------------------------------------
module haar_vertical_split #(
  parameter int MAX_WIDTH   = hvs_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT  = hvs_pkg::DefMaxHeight,
  parameter int SAMPLE_BITS = hvs_pkg::DefSampleBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hvs_pkg::ApbAddrBits-1:0] paddr,
  input  logic [hvs_pkg::ApbDataBits-1:0] pwdata,
  output logic [hvs_pkg::ApbDataBits-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [SAMPLE_BITS-1:0]          sample_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [SAMPLE_BITS-1:0]          coefficient_o,
  output logic [hvs_pkg::PosBits-1:0]     out_row_o,
  output logic [hvs_pkg::PosBits-1:0]     out_col_o,
  output logic                            is_highpass_o,
  output logic                            frame_done_o
);

  hvs_pkg::cfg_t          cfg;
  hvs_pkg::pos_t          s1_pos;
  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_sample;
  logic [SAMPLE_BITS-1:0] s1_even;
  logic                   out_free;

  hvs_cfg #(
    .MaxWidth  (MAX_WIDTH),
    .MaxHeight (MAX_HEIGHT)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hvs_front #(
    .MaxWidth   (MAX_WIDTH),
    .SampleBits (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_free_i  (out_free),
    .s1_valid_o  (s1_valid),
    .s1_sample_o (s1_sample),
    .s1_even_o   (s1_even),
    .s1_pos_o    (s1_pos)
  );

  hvs_back #(
    .SampleBits (SAMPLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s1_valid_i    (s1_valid),
    .s1_sample_i   (s1_sample),
    .s1_even_i     (s1_even),
    .s1_pos_i      (s1_pos),
    .out_free_o    (out_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .coefficient_o (coefficient_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .is_highpass_o (is_highpass_o),
    .frame_done_o  (frame_done_o)
  );

`ifndef SYNTH
  // an accepted transaction must occupy the input stage next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_valid)
    else $error("accepted sample lost before input stage");

  // a full input stage with a free output must reach the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && (!out_valid_o || !out_stall_i)) |=> out_valid_o)
    else $error("input stage did not advance to output");

  // output drains when nothing follows and the consumer takes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !s1_valid) |=> !out_valid_o)
    else $error("result repeated on output");

  // high-pass rows land below the low-pass half, never at row zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_highpass_o) |-> (out_row_o != '0))
    else $error("high-pass coefficient placed at row zero");
`endif

endmodule
